[rtl/core/four_level_page_walker_assert.svh]
// Assertion macros for the page walker.
`ifndef FOUR_LEVEL_PAGE_WALKER_ASSERT_SVH
`define FOUR_LEVEL_PAGE_WALKER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define FLPW_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("page walker check failed");
`define FLPW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("page walker check failed");
`else
`define FLPW_ASSERT_SAME(label, ante, cons)
`define FLPW_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/core/flpw_pkg.sv]
`timescale 1ns / 1ps
package flpw_pkg;

  localparam int PA_W    = 52;
  localparam int VA_W    = 48;
  localparam int ENTRY_W = 64;
  localparam int IDX_W   = 9;

  localparam logic KIND_TRANSLATE = 1'b0;
  localparam logic KIND_RESPONSE  = 1'b1;

  localparam logic RESULT_READ = 1'b0;
  localparam logic RESULT_DONE = 1'b1;

  localparam logic [1:0] LVL_TOP  = 2'd0;
  localparam logic [1:0] LVL_GIG  = 2'd1;
  localparam logic [1:0] LVL_TWOM = 2'd2;
  localparam logic [1:0] LVL_LEAF = 2'd3;

  localparam int PRESENT_POS = 0;
  localparam int LARGE_POS   = 7;

  typedef struct packed {
    logic               kind;
    logic [PA_W-1:0]    table_base;
    logic [VA_W-1:0]    virtual_address;
    logic [ENTRY_W-1:0] entry_value;
  } walk_req_t;

  typedef struct packed {
    logic            result_kind;
    logic [PA_W-1:0] read_address;
    logic [PA_W-1:0] phys_addr;
    logic            fault;
  } walk_rsp_t;

endpackage

[rtl/core/flpw_chan_if.sv]
`timescale 1ns / 1ps
interface flpw_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

[rtl/core/four_level_page_walker.sv]
// Output: a result reaches rsp in the cycle after its item is accepted when the
//   output register is free; behind a stalled rsp it waits in the skid register.
// Throughput: one item per cycle while the skid register is empty; a two-deep output
//   (register plus skid) keeps req ready while one result waits on a stalled rsp.
// Reset (rst, synchronous): walker idle at the top level, output stage empty.
`timescale 1ns / 1ps
`include "four_level_page_walker_assert.svh"
module four_level_page_walker
  import flpw_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  flpw_chan_if.sink    req,
  flpw_chan_if.source  rsp
);

  logic            walk_busy, walk_busy_next;
  logic [1:0]      walk_level, walk_level_next;
  logic [VA_W-1:0] held_address, held_address_next;

  logic      out_valid, skid_valid;
  walk_rsp_t out_data, skid_data;

  logic      accept;
  logic      has_result;
  walk_rsp_t res;

  logic [PA_W-1:0]  base_aligned;
  logic [IDX_W-1:0] next_idx;
  logic             present, large_page;

  assign req.ready = !skid_valid;
  assign accept    = req.valid && req.ready;
  assign rsp.valid = out_valid;
  assign rsp.payload = out_data;

  assign base_aligned = {req.payload.table_base[PA_W-1:4], 4'b0};
  assign present      = req.payload.entry_value[PRESENT_POS];
  assign large_page   = req.payload.entry_value[LARGE_POS];

  always_comb begin
    unique case (walk_level)
      LVL_TOP:  next_idx = held_address[38:30];
      LVL_GIG:  next_idx = held_address[29:21];
      LVL_TWOM: next_idx = held_address[20:12];
      default:  next_idx = '0;
    endcase
  end

  always_comb begin
    walk_busy_next    = walk_busy;
    walk_level_next   = walk_level;
    held_address_next = held_address;
    has_result        = 1'b0;
    res               = '0;
    if (req.payload.kind == KIND_TRANSLATE) begin
      if (!walk_busy) begin
        has_result        = 1'b1;
        walk_busy_next    = 1'b1;
        walk_level_next   = LVL_TOP;
        held_address_next = req.payload.virtual_address;
        res.result_kind   = RESULT_READ;
        res.read_address  = base_aligned
                          + {{(PA_W-IDX_W-3){1'b0}}, req.payload.virtual_address[47:39], 3'b0};
      end
    end else if (walk_busy) begin
      has_result      = 1'b1;
      res.result_kind = RESULT_DONE;
      walk_busy_next  = 1'b0;
      walk_level_next = LVL_TOP;
      priority if (!present) begin
        res.fault = 1'b1;
      end else if (walk_level == LVL_LEAF) begin
        if (req.payload.entry_value[PA_W-1:12] == '0) begin
          res.fault = 1'b1;
        end else begin
          res.phys_addr = {req.payload.entry_value[PA_W-1:12], held_address[11:0]};
        end
      end else if (walk_level == LVL_GIG && large_page) begin
        res.phys_addr = {req.payload.entry_value[PA_W-1:30], held_address[29:0]};
      end else if (walk_level == LVL_TWOM && large_page) begin
        res.phys_addr = {req.payload.entry_value[PA_W-1:21], held_address[20:0]};
      end else begin
        res.result_kind   = RESULT_READ;
        walk_busy_next    = 1'b1;
        walk_level_next   = walk_level + 2'd1;
        res.read_address  = {req.payload.entry_value[PA_W-1:12], next_idx, 3'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_busy    <= 1'b0;
      walk_level   <= LVL_TOP;
      held_address <= '0;
    end else if (accept) begin
      walk_busy    <= walk_busy_next;
      walk_level   <= walk_level_next;
      held_address <= held_address_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (rsp.ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept && has_result;
      end
    end else if (accept && has_result) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.ready || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else begin
        out_data <= res;
      end
    end else if (accept && has_result) begin
      skid_data <= res;
    end
  end

  `FLPW_ASSERT_SAME(a_skid_behind_out, skid_valid, out_valid)
  `FLPW_ASSERT_SAME(a_fault_is_done, out_valid && out_data.fault,
                    out_data.result_kind == RESULT_DONE && out_data.phys_addr == '0)
  `FLPW_ASSERT_NEXT(a_start_walk,
                    accept && req.payload.kind == KIND_TRANSLATE && !walk_busy,
                    walk_busy && walk_level == LVL_TOP)
  `FLPW_ASSERT_NEXT(a_leaf_ends,
                    accept && req.payload.kind == KIND_RESPONSE && walk_busy &&
                    walk_level == LVL_LEAF,
                    !walk_busy)

endmodule

[tb/four_level_page_walker_tb.sv]
`timescale 1ns / 1ps
module four_level_page_walker_tb
  import flpw_pkg::*;
();

  localparam int CYCLE_LIMIT = 400000;
  localparam int WALK_TARGET = 1000;

  typedef struct {
    walk_req_t item;
    bit        drain_first;
  } stim_t;

  logic clk;
  logic rst;

  flpw_chan_if #(.payload_t(walk_req_t)) req_if ();
  flpw_chan_if #(.payload_t(walk_rsp_t)) rsp_if ();

  four_level_page_walker uut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  stim_t     pending_q[$];
  walk_rsp_t expect_q[$];
  walk_rsp_t want_rsp;
  walk_rsp_t next_rsp;
  stim_t     cur_stim;

  int  errors;
  int  cycles;
  int  walk_items;
  int  req_gap;
  int  rsp_stall;
  bit  req_taken;

  // walker model state
  bit               pw_busy;
  logic [1:0]       pw_level;
  logic [VA_W-1:0]  pw_va;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int idle_len();
    int r;
    if (cycles % 3000 < 500) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [IDX_W-1:0] va_index(input logic [VA_W-1:0] va,
                                                 input logic [1:0] lvl);
    return IDX_W'(va >> (39 - 9 * int'(lvl)));
  endfunction

  function automatic bit walk_step(input walk_req_t it, output walk_rsp_t res);
    logic [PA_W-1:0]    frame4k;
    logic [ENTRY_W-1:0] e;
    e = it.entry_value;
    res = '0;
    if (it.kind == KIND_TRANSLATE) begin
      if (pw_busy) return 1'b0;
      pw_busy  = 1'b1;
      pw_level = LVL_TOP;
      pw_va    = it.virtual_address;
      res.result_kind  = RESULT_READ;
      res.read_address = {it.table_base[PA_W-1:4], 4'h0} +
                         (PA_W'(va_index(pw_va, LVL_TOP)) << 3);
      return 1'b1;
    end
    if (!pw_busy) return 1'b0;
    frame4k = {e[PA_W-1:12], 12'h0};
    res.result_kind = RESULT_DONE;
    if (!e[PRESENT_POS]) begin
      res.fault = 1'b1;
    end else if (pw_level == LVL_LEAF) begin
      if (frame4k == '0) res.fault = 1'b1;
      else res.phys_addr = {e[PA_W-1:12], pw_va[11:0]};
    end else if (pw_level == LVL_GIG && e[LARGE_POS]) begin
      res.phys_addr = {e[PA_W-1:30], pw_va[29:0]};
    end else if (pw_level == LVL_TWOM && e[LARGE_POS]) begin
      res.phys_addr = {e[PA_W-1:21], pw_va[20:0]};
    end else begin
      pw_level = pw_level + 2'd1;
      res.result_kind  = RESULT_READ;
      res.read_address = frame4k + (PA_W'(va_index(pw_va, pw_level)) << 3);
      return 1'b1;
    end
    pw_busy  = 1'b0;
    pw_level = LVL_TOP;
    return 1'b1;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [PA_W-1:0] rand_base();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PA_W'(rand64());
  endfunction

  function automatic logic [VA_W-1:0] rand_va();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return VA_W'(rand64());
  endfunction

  task automatic queue_item(input logic kind, input logic [PA_W-1:0] base,
                            input logic [VA_W-1:0] va, input logic [63:0] entry,
                            input bit drain);
    stim_t s;
    s.item.kind            = kind;
    s.item.table_base      = base;
    s.item.virtual_address = va;
    s.item.entry_value     = entry;
    s.drain_first          = drain;
    pending_q.push_back(s);
  endtask

  task automatic queue_translate(input logic [PA_W-1:0] base, input logic [VA_W-1:0] va,
                                 input bit drain);
    queue_item(KIND_TRANSLATE, base, va, rand64(), drain);
  endtask

  task automatic queue_entry(input logic [63:0] entry);
    queue_item(KIND_RESPONSE, rand_base(), rand_va(), entry, 1'b0);
  endtask

  // well-formed walk with a random outcome at each level
  task automatic queue_walk(input bit drain);
    logic [63:0] e;
    int          lvl;
    int          r;
    bit          done;
    done = 1'b0;
    queue_translate(rand_base(), rand_va(), drain);
    walk_items++;
    for (lvl = 0; lvl < 4 && !done; lvl++) begin
      if ($urandom_range(0, 19) == 0) queue_translate(rand_base(), rand_va(), 1'b0);
      e = rand64();
      if ($urandom_range(0, 15) == 0) e[51:12] = '1;
      r = $urandom_range(0, 99);
      if (r < 6) begin
        e[PRESENT_POS] = 1'b0;
        done = 1'b1;
      end else begin
        e[PRESENT_POS] = 1'b1;
        if ((lvl == 1 || lvl == 2) && r < 22) begin
          e[LARGE_POS] = 1'b1;
          done = 1'b1;
        end else if (lvl == 3) begin
          if (r < 14) e[51:12] = '0;
          done = 1'b1;
        end else if (lvl == 1 || lvl == 2) begin
          e[LARGE_POS] = 1'b0;
        end
      end
      queue_entry(e);
      walk_items++;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // acceptance and prediction
  always @(posedge clk) begin
    if (rst) begin
      pw_busy  = 1'b0;
      pw_level = LVL_TOP;
      pw_va    = '0;
    end else if (req_if.valid && req_if.ready) begin
      req_taken = 1'b1;
      if (walk_step(req_if.payload, next_rsp)) expect_q.push_back(next_rsp);
    end
  end

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else if (req_if.valid && !req_taken) begin
      req_if.valid <= 1'b1;
    end else begin
      req_taken = 1'b0;
      if (req_gap > 0) begin
        req_gap--;
        req_if.valid <= 1'b0;
      end else if (pending_q.size() != 0 && pending_q[0].drain_first &&
                   expect_q.size() != 0) begin
        req_if.valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        cur_stim = pending_q.pop_front();
        req_if.valid   <= 1'b1;
        req_if.payload <= cur_stim.item;
        req_gap = idle_len();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // result ready with random stalls
  always @(negedge clk) begin
    if (rsp_stall > 0) begin
      rsp_stall--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
      rsp_stall = idle_len();
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expect_q.size() == 0) begin
        report_mismatch("unexpected result", 64'(rsp_if.payload.read_address), 64'h0);
      end else begin
        want_rsp = expect_q.pop_front();
        if (rsp_if.payload.result_kind !== want_rsp.result_kind)
          report_mismatch("result_kind", 64'(rsp_if.payload.result_kind),
                          64'(want_rsp.result_kind));
        if (rsp_if.payload.read_address !== want_rsp.read_address)
          report_mismatch("read_address", 64'(rsp_if.payload.read_address),
                          64'(want_rsp.read_address));
        if (rsp_if.payload.phys_addr !== want_rsp.phys_addr)
          report_mismatch("phys_addr", 64'(rsp_if.payload.phys_addr),
                          64'(want_rsp.phys_addr));
        if (rsp_if.payload.fault !== want_rsp.fault)
          report_mismatch("fault", 64'(rsp_if.payload.fault), 64'(want_rsp.fault));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    errors         = 0;
    cycles         = 0;
    walk_items     = 0;
    req_gap        = 0;
    rsp_stall      = 0;
    req_taken      = 1'b0;

    // directed: idle response, carry at max fields, large bit ignored at top and leaf
    queue_entry('1);
    queue_translate('1, '1, 1'b0);
    queue_entry('1);
    queue_entry(64'hFFFF_FFFF_FFFF_FF7F);
    queue_translate(52'h0_1234_5678_9ABC, 48'h1234_5678_9ABC, 1'b0);
    queue_entry(64'hFFFF_FFFF_FFFF_FF7F);
    queue_entry('1);
    // all-zero request, not present at top
    queue_translate('0, '0, 1'b0);
    queue_entry('0);
    // 1 GiB page
    queue_translate(52'h0_0000_0000_100F, 48'h0000_4020_1003, 1'b0);
    queue_entry(64'h0000_0000_0000_1001);
    queue_entry('1);
    // 2 MiB page
    queue_translate(52'h0_0000_0020_0000, 48'h7FFF_FFFF_FFFF, 1'b0);
    queue_entry(64'h0000_0000_0000_3003);
    queue_entry(64'h8000_0000_0000_4003);
    queue_entry(64'h8000_0000_0020_0081);
    // leaf frame zero
    queue_translate(52'h0_0000_0000_8000, 48'h8000_0000_0000, 1'b0);
    queue_entry(64'h0000_0000_0000_5001);
    queue_entry(64'h0000_0000_0000_6001);
    queue_entry(64'h0000_0000_0000_7001);
    queue_entry(64'hFFF0_0000_0000_0FFF);
    // not present at the third level
    queue_translate(52'h0_0000_0000_9000, 48'h0000_0000_0FFF, 1'b0);
    queue_entry(64'h0000_0000_0000_1003);
    queue_entry(64'h0000_0000_0000_2003);
    queue_entry(64'hFFFF_FFFF_FFFF_FFFE);

    while (walk_items < WALK_TARGET) begin
      if ($urandom_range(0, 19) == 0) queue_entry(rand64());
      queue_walk(walk_items == 0 || $urandom_range(0, 60) == 0);
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_q.size() != 0 || req_if.valid || expect_q.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
